[rtl/core/jtag_vector_shift_engine_defines.svh]
// Assertion macros shared by the JTAG shifter RTL.
// All users clock on aclk and reset on aresetn.
`ifndef JTAG_VECTOR_SHIFT_ENGINE_DEFINES_SVH
`define JTAG_VECTOR_SHIFT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

`define JVSE_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("jvse check failed");

`define JVSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jvse check failed");

`else

`define JVSE_ASSERT(label, prop)

`define JVSE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/jvse_pkg.sv]
`timescale 1ns / 1ps

package jvse_pkg;

    localparam int SHIFT_WIDTH = 32;
    localparam int CNT_W       = $clog2(SHIFT_WIDTH + 1);
    localparam int IDX_W       = $clog2(SHIFT_WIDTH);
    localparam int DATA_W      = 32;
    localparam int DIV_W       = 8;
    localparam int DLY_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    typedef logic [SHIFT_WIDTH-1:0] shift_word_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [DATA_W-1:0]      data_t;

    localparam cnt_t  LENGTH_RESET = CNT_W'(SHIFT_WIDTH);
    localparam data_t LENGTH_MAX   = DATA_W'(SHIFT_WIDTH);

    typedef enum logic [2:0] {
        KIND_WRITE_LENGTH = 3'd0,
        KIND_WRITE_TMS    = 3'd1,
        KIND_WRITE_TDI    = 3'd2,
        KIND_START        = 3'd3,
        KIND_READ_TDO     = 3'd4,
        KIND_READ_BUSY    = 3'd5,
        KIND_TICK         = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_DIVIDER = 1'b0,
        CFG_CAPTURE_DELAY = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] kind;
        data_t      write_data;
        logic       tdo_pin;
    } in_item_t;

    typedef struct packed {
        data_t read_data;
        logic  tck_pin;
        logic  tms_pin;
        logic  tdi_pin;
        logic  busy_res;
    } result_t;

endpackage

[rtl/core/jvse_core.sv]
`timescale 1ns / 1ps

`include "jtag_vector_shift_engine_defines.svh"

module jvse_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [jvse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jvse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                item_fire,
    input  jvse_pkg::in_item_t                  item,
    output jvse_pkg::result_t                   result
);

    logic [jvse_pkg::DIV_W-1:0] clock_divider_reg, clock_divider_next;
    logic [jvse_pkg::DLY_W-1:0] capture_delay_reg, capture_delay_next;

    jvse_pkg::shift_word_t      tms_shift_reg, tms_shift_next;
    jvse_pkg::shift_word_t      tdi_shift_reg, tdi_shift_next;
    jvse_pkg::shift_word_t      tdo_capture_reg, tdo_capture_next;
    jvse_pkg::cnt_t             bit_length_reg, bit_length_next;
    jvse_pkg::cnt_t             bits_done_reg, bits_done_next;
    logic [jvse_pkg::DIV_W-1:0] divider_count_reg, divider_count_next;
    logic [jvse_pkg::DLY_W-1:0] delay_count_reg, delay_count_next;
    logic                       tck_level_reg, tck_level_next;
    logic                       running_reg, running_next;

    function automatic jvse_pkg::shift_word_t shift_in_sample(
        jvse_pkg::shift_word_t cap,
        logic                  pin
    );
        return {pin, cap[jvse_pkg::SHIFT_WIDTH-1:1]};
    endfunction

    // configuration writes
    always_comb begin
        clock_divider_next = clock_divider_reg;
        capture_delay_next = capture_delay_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                jvse_pkg::CFG_CLOCK_DIVIDER: clock_divider_next = cfg_wdata[jvse_pkg::DIV_W-1:0];
                jvse_pkg::CFG_CAPTURE_DELAY: capture_delay_next = cfg_wdata[jvse_pkg::DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // one item: state update and result from the updated state
    always_comb begin
        jvse_pkg::data_t read_data;
        logic            at_end;

        tms_shift_next     = tms_shift_reg;
        tdi_shift_next     = tdi_shift_reg;
        tdo_capture_next   = tdo_capture_reg;
        bit_length_next    = bit_length_reg;
        bits_done_next     = bits_done_reg;
        divider_count_next = divider_count_reg;
        delay_count_next   = delay_count_reg;
        tck_level_next     = tck_level_reg;
        running_next       = running_reg;
        read_data          = '0;
        at_end             = 1'b0;

        unique case (item.kind)
            jvse_pkg::KIND_WRITE_LENGTH: begin
                if (!running_reg) begin
                    if (item.write_data == '0) begin
                        bit_length_next = jvse_pkg::CNT_W'(1);
                    end else if (item.write_data > jvse_pkg::LENGTH_MAX) begin
                        bit_length_next = jvse_pkg::LENGTH_RESET;
                    end else begin
                        bit_length_next = item.write_data[jvse_pkg::CNT_W-1:0];
                    end
                end
            end
            jvse_pkg::KIND_WRITE_TMS: begin
                if (!running_reg) begin
                    tms_shift_next = jvse_pkg::shift_word_t'(item.write_data);
                end
            end
            jvse_pkg::KIND_WRITE_TDI: begin
                if (!running_reg) begin
                    tdi_shift_next = jvse_pkg::shift_word_t'(item.write_data);
                end
            end
            jvse_pkg::KIND_START: begin
                if (!running_reg) begin
                    running_next       = 1'b1;
                    bits_done_next     = '0;
                    divider_count_next = '0;
                    delay_count_next   = '0;
                    tck_level_next     = 1'b0;
                    tdo_capture_next   = '0;
                end
            end
            jvse_pkg::KIND_READ_TDO: begin
                read_data = jvse_pkg::data_t'(tdo_capture_reg);
            end
            jvse_pkg::KIND_READ_BUSY: begin
                read_data = jvse_pkg::data_t'(running_reg);
            end
            jvse_pkg::KIND_TICK: begin
                if (running_reg) begin
                    // pending delayed sample comes due
                    if (delay_count_reg != '0) begin
                        delay_count_next = delay_count_reg - jvse_pkg::DLY_W'(1);
                        if (delay_count_reg == jvse_pkg::DLY_W'(1)) begin
                            tdo_capture_next = shift_in_sample(tdo_capture_reg, item.tdo_pin);
                        end
                    end
                    // clock runs until the last falling edge
                    if (bits_done_reg < bit_length_reg) begin
                        if (divider_count_reg >= clock_divider_reg) begin
                            divider_count_next = '0;
                            tck_level_next     = !tck_level_reg;
                            if (!tck_level_reg) begin
                                // rising edge: flush a sample still pending
                                if (delay_count_next != '0) begin
                                    tdo_capture_next = shift_in_sample(tdo_capture_next,
                                                                       item.tdo_pin);
                                end
                                if (capture_delay_reg == '0) begin
                                    tdo_capture_next = shift_in_sample(tdo_capture_next,
                                                                       item.tdo_pin);
                                    delay_count_next = '0;
                                end else begin
                                    delay_count_next = capture_delay_reg;
                                end
                            end else begin
                                bits_done_next = bits_done_reg + jvse_pkg::CNT_W'(1);
                            end
                        end else begin
                            divider_count_next = divider_count_reg + jvse_pkg::DIV_W'(1);
                        end
                    end
                    at_end = (bits_done_next >= bit_length_next);
                    if (at_end && delay_count_next == '0) begin
                        running_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        result.read_data = read_data;
        result.tck_pin   = tck_level_next;
        result.busy_res  = running_next;
        if (running_next && bits_done_next < bit_length_next) begin
            result.tms_pin = tms_shift_next[bits_done_next[jvse_pkg::IDX_W-1:0]];
            result.tdi_pin = tdi_shift_next[bits_done_next[jvse_pkg::IDX_W-1:0]];
        end else begin
            result.tms_pin = 1'b0;
            result.tdi_pin = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_divider_reg <= '0;
            capture_delay_reg <= '0;
            tms_shift_reg     <= '0;
            tdi_shift_reg     <= '0;
            tdo_capture_reg   <= '0;
            bit_length_reg    <= jvse_pkg::LENGTH_RESET;
            bits_done_reg     <= '0;
            divider_count_reg <= '0;
            delay_count_reg   <= '0;
            tck_level_reg     <= 1'b0;
            running_reg       <= 1'b0;
        end else begin
            clock_divider_reg <= clock_divider_next;
            capture_delay_reg <= capture_delay_next;
            if (item_fire) begin
                tms_shift_reg     <= tms_shift_next;
                tdi_shift_reg     <= tdi_shift_next;
                tdo_capture_reg   <= tdo_capture_next;
                bit_length_reg    <= bit_length_next;
                bits_done_reg     <= bits_done_next;
                divider_count_reg <= divider_count_next;
                delay_count_reg   <= delay_count_next;
                tck_level_reg     <= tck_level_next;
                running_reg       <= running_next;
            end
        end
    end

    `JVSE_ASSERT(a_done_in_range, !running_reg || bits_done_reg <= bit_length_reg)
    `JVSE_ASSERT(a_idle_no_pending, running_reg || delay_count_reg == '0)
    `JVSE_ASSERT(a_tck_only_running, !tck_level_reg || running_reg)
    `JVSE_ASSERT(a_length_legal, bit_length_reg != '0 && bit_length_reg <= jvse_pkg::LENGTH_RESET)

endmodule

[rtl/core/jvse_out_buf.sv]
`timescale 1ns / 1ps

`include "jtag_vector_shift_engine_defines.svh"

module jvse_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  jvse_pkg::result_t push_data,
    output logic              push_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output jvse_pkg::result_t m_data
);

    logic              out_valid_reg, out_valid_next;
    jvse_pkg::result_t out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    jvse_pkg::result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            // output slot frees up; skid entry goes first
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    `JVSE_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `JVSE_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_reg && !m_ready, skid_valid_reg)

endmodule

[rtl/core/jtag_vector_shift_engine.sv]
// Each result is registered in the output buffer before it shows on m_valid.
// Throughput: one item per cycle; a two-entry output buffer keeps s_ready
// high while one result waits, so s_ready only drops with both entries full.
// Reset (aresetn low, synchronous): config registers 0, length 32, all shift
// state and TCK cleared, block idle, no result pending.
`timescale 1ns / 1ps

module jtag_vector_shift_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [jvse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jvse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  jvse_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output jvse_pkg::result_t               m_data
);

    logic              item_fire;
    jvse_pkg::result_t result;

    assign item_fire = s_valid && s_ready;

    jvse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_fire (item_fire),
        .item      (s_data),
        .result    (result)
    );

    jvse_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (item_fire),
        .push_data  (result),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[tb/jtag_vector_shift_engine_check.sv]
`timescale 1ns / 1ps

module jtag_vector_shift_engine_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [jvse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jvse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  jvse_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  jvse_pkg::result_t               m_data,
    output int                              mismatches,
    output int                              pending
);
    import jvse_pkg::*;

    // shadow of the configuration registers
    logic [DIV_W-1:0] half_period_cfg;
    logic [DLY_W-1:0] sample_delay_cfg;

    // shadow of the shifter state
    shift_word_t      tms_word;
    shift_word_t      tdi_word;
    shift_word_t      capture_word;
    cnt_t             vec_len;
    cnt_t             bits_shifted;
    logic [DIV_W-1:0] div_count;
    logic [DLY_W-1:0] sample_wait;
    logic             tck_lvl;
    logic             shifting;

    result_t          expected_pins_q[$];
    int               error_count;

    task automatic clear_shifter();
        half_period_cfg  = '0;
        sample_delay_cfg = '0;
        tms_word         = '0;
        tdi_word         = '0;
        capture_word     = '0;
        vec_len          = cnt_t'(SHIFT_WIDTH);
        bits_shifted     = '0;
        div_count        = '0;
        sample_wait      = '0;
        tck_lvl          = 1'b0;
        shifting         = 1'b0;
    endtask

    task automatic capture_tdo(input logic pin);
        capture_word = {pin, capture_word[SHIFT_WIDTH-1:1]};
    endtask

    task automatic advance_tck(input logic pin);
        if (sample_wait != 0) begin
            sample_wait = sample_wait - DLY_W'(1);
            if (sample_wait == 0)
                capture_tdo(pin);
        end
        // clock stops after the last falling edge; only a pending sample drains
        if (bits_shifted < vec_len) begin
            if (div_count >= half_period_cfg) begin
                div_count = '0;
                tck_lvl   = ~tck_lvl;
                if (tck_lvl) begin
                    // a sample still pending at the next rising edge is taken now
                    if (sample_wait != 0)
                        capture_tdo(pin);
                    if (sample_delay_cfg == 0) begin
                        capture_tdo(pin);
                        sample_wait = '0;
                    end else begin
                        sample_wait = sample_delay_cfg;
                    end
                end else begin
                    bits_shifted = bits_shifted + CNT_W'(1);
                end
            end else begin
                div_count = div_count + DIV_W'(1);
            end
        end
    endtask

    task automatic step_shifter(input in_item_t item, output result_t res);
        data_t rd;
        rd = '0;
        case (item.kind)
            KIND_WRITE_LENGTH: begin
                if (!shifting) begin
                    if (item.write_data == 0)
                        vec_len = cnt_t'(1);
                    else if (item.write_data > SHIFT_WIDTH)
                        vec_len = cnt_t'(SHIFT_WIDTH);
                    else
                        vec_len = cnt_t'(item.write_data);
                end
            end
            KIND_WRITE_TMS: begin
                if (!shifting)
                    tms_word = shift_word_t'(item.write_data);
            end
            KIND_WRITE_TDI: begin
                if (!shifting)
                    tdi_word = shift_word_t'(item.write_data);
            end
            KIND_START: begin
                if (!shifting) begin
                    shifting     = 1'b1;
                    bits_shifted = '0;
                    div_count    = '0;
                    sample_wait  = '0;
                    tck_lvl      = 1'b0;
                    capture_word = '0;
                end
            end
            KIND_READ_TDO:  rd = data_t'(capture_word);
            KIND_READ_BUSY: rd = data_t'(shifting);
            KIND_TICK: begin
                if (shifting) begin
                    advance_tck(item.tdo_pin);
                    if (bits_shifted >= vec_len && sample_wait == 0)
                        shifting = 1'b0;
                end
            end
            default: ;
        endcase
        res.read_data = rd;
        res.tck_pin   = tck_lvl;
        if (shifting && bits_shifted < vec_len) begin
            res.tms_pin = tms_word[bits_shifted[IDX_W-1:0]];
            res.tdi_pin = tdi_word[bits_shifted[IDX_W-1:0]];
        end else begin
            res.tms_pin = 1'b0;
            res.tdi_pin = 1'b0;
        end
        res.busy_res = shifting;
    endtask

    task automatic check_field(input string name, input data_t want, input data_t got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        result_t predicted;
        if (!aresetn) begin
            clear_shifter();
            expected_pins_q.delete();
            error_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_CLOCK_DIVIDER)
                    half_period_cfg = cfg_wdata[DIV_W-1:0];
                else
                    sample_delay_cfg = cfg_wdata[DLY_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (expected_pins_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_data);
                    error_count++;
                end else begin
                    want = expected_pins_q.pop_front();
                    check_field("read_data", want.read_data, m_data.read_data);
                    check_field("tck_pin", data_t'(want.tck_pin), data_t'(m_data.tck_pin));
                    check_field("tms_pin", data_t'(want.tms_pin), data_t'(m_data.tms_pin));
                    check_field("tdi_pin", data_t'(want.tdi_pin), data_t'(m_data.tdi_pin));
                    check_field("busy_res", data_t'(want.busy_res),
                                data_t'(m_data.busy_res));
                end
            end
            if (s_valid && s_ready) begin
                step_shifter(s_data, predicted);
                expected_pins_q.push_back(predicted);
            end
        end
        pending    <= expected_pins_q.size();
        mismatches <= error_count;
    end

endmodule

[tb/jtag_vector_shift_engine_test.sv]
`timescale 1ns / 1ps

module jtag_vector_shift_engine_test;
    import jvse_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int TICK_CAP    = 200;
    localparam int PHASE_ITEMS = 10;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    result_t    m_data;

    int          mismatches;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_asked = 0;
    int          hold_taken = 0;
    int          hold_left  = 0;
    int          idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned div_now = 0;
    int unsigned dly_now = 0;

    always #6 aclk = ~aclk;

    jtag_vector_shift_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    jtag_vector_shift_engine_check i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver: random back-pressure, plus a long hold when asked
    always @(posedge aclk) begin
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] kind, input data_t data, input logic pin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{kind: kind, write_data: data, tdo_pin: pin};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic tick(input logic pin);
        send_item(KIND_TICK, $urandom(), pin);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic reconfigure(input int unsigned div, input int unsigned dly);
        drain();
        div_now   = div;
        dly_now   = dly;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CLOCK_DIVIDER;
        cfg_wdata <= CFG_DATA_W'(div);
        @(posedge aclk);
        cfg_index <= CFG_CAPTURE_DELAY;
        // upper bits are don't-care for the delay register
        cfg_wdata <= {4'($urandom_range(15)), 4'(dly)};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic shift_vector(input data_t len_word, input bit noisy);
        int unsigned bits;
        int unsigned ticks;
        bits  = (len_word == 0) ? 1 : (len_word > SHIFT_WIDTH) ? SHIFT_WIDTH : len_word;
        ticks = 2 * bits * (div_now + 1) + dly_now + 2;
        if (noisy) begin
            if (ticks > TICK_CAP)
                ticks = TICK_CAP;
            // cut some vectors short so later writes and starts hit a busy shifter
            if ($urandom_range(99) < 15)
                ticks = $urandom_range(ticks);
        end
        send_item(KIND_WRITE_LENGTH, len_word, 1'($urandom_range(1)));
        send_item(KIND_WRITE_TMS, $urandom(), 1'($urandom_range(1)));
        send_item(KIND_WRITE_TDI, $urandom(), 1'($urandom_range(1)));
        send_item(KIND_START, $urandom(), 1'($urandom_range(1)));
        for (int unsigned i = 0; i < ticks; i++) begin
            if (noisy && $urandom_range(99) < 12)
                send_item(3'($urandom_range(7)), $urandom(), 1'($urandom_range(1)));
            tick(1'($urandom_range(1)));
        end
        send_item(KIND_READ_BUSY, $urandom(), 1'($urandom_range(1)));
        send_item(KIND_READ_TDO, $urandom(), 1'($urandom_range(1)));
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned stop_at;
        data_t       len_word;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(9))
                    0:       len_word = '0;
                    1:       len_word = $urandom_range(33, 40);
                    2:       len_word = $urandom();
                    3:       len_word = SHIFT_WIDTH;
                    4:       len_word = $urandom_range(9, 31);
                    default: len_word = $urandom_range(1, 8);
                endcase
                shift_vector(len_word, 1'b1);
            end else begin
                send_item(3'($urandom_range(7)), $urandom(), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_CLOCK_DIVIDER;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 37;
        recv_idle_pct = 74;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // idle block: reads, stray tick, unused kind
        send_item(KIND_READ_BUSY, '1, 1'b1);
        send_item(KIND_READ_TDO, '1, 1'b0);
        tick(1'b1);
        send_item(KIND_UNUSED, '1, 1'b1);
        // zero length taken as one bit; writes and start ignored while busy
        send_item(KIND_WRITE_LENGTH, '0, 1'b0);
        send_item(KIND_WRITE_TMS, '1, 1'b0);
        send_item(KIND_WRITE_TDI, '0, 1'b0);
        send_item(KIND_START, '0, 1'b0);
        send_item(KIND_WRITE_LENGTH, 32'd5, 1'b0);
        send_item(KIND_START, '1, 1'b0);
        send_item(KIND_WRITE_TMS, '0, 1'b0);
        tick(1'b1);
        send_item(KIND_READ_BUSY, '0, 1'b0);
        tick(1'b0);
        send_item(KIND_READ_BUSY, '0, 1'b0);
        send_item(KIND_READ_TDO, '0, 1'b0);
        // oversize lengths clamp to the word width
        send_item(KIND_WRITE_LENGTH, '1, 1'b0);
        send_item(KIND_WRITE_LENGTH, 32'd33, 1'b0);
        send_item(KIND_WRITE_LENGTH, 32'd2, 1'b0);
        send_item(KIND_WRITE_TMS, '0, 1'b0);
        send_item(KIND_WRITE_TDI, '1, 1'b0);
        send_item(KIND_START, '0, 1'b0);
        tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        send_item(KIND_READ_TDO, '0, 1'b0);

        // divider lowered below the running count mid-shift
        reconfigure(3, 2);
        send_item(KIND_WRITE_LENGTH, 32'd1, 1'b0);
        send_item(KIND_START, '0, 1'b0);
        tick(1'b1);
        tick(1'b0);
        reconfigure(0, 2);
        repeat (4) tick(1'($urandom_range(1)));
        send_item(KIND_READ_TDO, '0, 1'b0);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 74 : 0;
            recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 37 : 0;
            if (mode == 2) begin
                // slowest TCK and longest sample delay, one full bit
                reconfigure(255, 15);
                shift_vector(32'd1, 1'b0);
            end
            reconfigure(0, 15);
            if (mode == 2)
                hold_asked++;
            random_phase(PHASE_ITEMS);
            reconfigure($urandom_range(3), 0);
            random_phase(PHASE_ITEMS);
            reconfigure($urandom_range(3), $urandom_range(15));
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
